// File: rtl/assert_macros.svh
// assertion macros used by hybrid_probe_hash_counter_table
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/hphct_pkg.sv
// package for the hybrid probe hash counter table
// types, constants and command codes; no dependencies
package hphct_pkg;
  localparam int unsigned DefSlots = 4096;
  localparam logic [31:0] HashMul = 32'd12289;
  localparam int unsigned SizeW = 13;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_INC = 2'd1,
    CMD_GET = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DENSE_RD,
    S_DENSE_CHK,
    S_RAW_RD,
    S_RAW_CHK,
    S_OUT
  } state_t;

  localparam logic [0:0] REG_SIZE = 1'b0;
  localparam logic [0:0] REG_SENT = 1'b1;
endpackage

// File: rtl/hphct_ram.sv
// generic single-port ram with registered read
// no dependencies
module hphct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/hybrid_probe_hash_counter_table.sv
// hybrid probe hash counter table: key/value counters, hashed and dense regions
// each transaction: hash, then raw or dense read and check (dense range error: to out)
// or modulo reduction and a read and check per probed slot; idle again before the next
// sync reset: size 4096, sentinel 0, sweeps all four memories, no transaction taken
// depends on hphct_pkg, hphct_ram and assert_macros.svh
`include "assert_macros.svh"
module hybrid_probe_hash_counter_table
  import hphct_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] key,
  input  logic [31:0] new_value,
  input  logic [12:0] slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic [31:0] result_key,
  output logic [1:0]  status
);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned DW = CW + 31;

  state_t state, state_next;
  logic [SizeW-1:0] table_size;
  logic [31:0] sentinel;
  logic [CW-1:0] size;
  logic [CW-1:0] probes;
  logic [AW-1:0] clr_addr;
  logic [1:0] op;
  logic [31:0] k, nv;
  logic [12:0] idx;
  logic [31:0] prod;
  logic [31:0] rem;
  logic [31:0] rem_step;
  logic [DW-1:0] dsh;
  logic [4:0] mstep;
  logic [AW-1:0] slot;
  logic use_dense;
  logic [AW-1:0] addr;
  logic hk_we, hv_we, dk_we, dv_we;
  logic [31:0] kw, vw;
  logic [31:0] hk_q, hv_q, dk_q, dv_q;
  logic [31:0] cur_k, cur_v;
  logic [31:0] dsub;
  logic [13:0] ridx;

  always_comb begin
    if (table_size == '0) begin
      size = CW'(1);
    end else if ({19'd0, table_size} > 32'(SLOTS)) begin
      size = CW'(SLOTS);
    end else begin
      size = CW'(table_size);
    end
  end

  assign dsub = k - sentinel;
  assign ridx = {1'b0, idx} - 14'(size);
  assign cur_k = use_dense ? dk_q : hk_q;
  assign cur_v = use_dense ? dv_q : hv_q;
  assign rem_step = (DW'(rem) >= dsh) ? rem - dsh[31:0] : rem;

  hphct_ram #(.Width(32), .Depth(SLOTS)) u_hk (
    .clk(clk), .we(hk_we), .addr(addr), .wdata(kw), .rdata(hk_q));
  hphct_ram #(.Width(32), .Depth(SLOTS)) u_hv (
    .clk(clk), .we(hv_we), .addr(addr), .wdata(vw), .rdata(hv_q));
  hphct_ram #(.Width(32), .Depth(SLOTS)) u_dk (
    .clk(clk), .we(dk_we), .addr(addr), .wdata(kw), .rdata(dk_q));
  hphct_ram #(.Width(32), .Depth(SLOTS)) u_dv (
    .clk(clk), .we(dv_we), .addr(addr), .wdata(vw), .rdata(dv_q));

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    hk_we = 1'b0;
    hv_we = 1'b0;
    dk_we = 1'b0;
    dv_we = 1'b0;
    kw = k;
    vw = nv;
    addr = slot;
    case (state)
      S_CLEAR: begin
        addr = clr_addr;
        kw = '0;
        vw = '0;
        hk_we = 1'b1;
        hv_we = 1'b1;
        dk_we = 1'b1;
        dv_we = 1'b1;
        if (clr_addr == AW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (op == CMD_READ) begin
          state_next = S_RAW_RD;
        end else if (k > sentinel) begin
          state_next = S_DENSE_RD;
        end else begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (mstep == 5'd31) begin
          state_next = S_PROBE_RD;
        end
      end
      S_PROBE_RD: state_next = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (hk_q == '0 || hk_q == k) begin
          if (op == CMD_SET) begin
            hk_we = 1'b1;
            hv_we = 1'b1;
          end else if (op == CMD_INC) begin
            hk_we = 1'b1;
            hv_we = 1'b1;
            vw = hv_q + 32'd1;
          end
          state_next = S_OUT;
        end else if (probes == size - CW'(1)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PROBE_RD;
        end
      end
      S_DENSE_RD: begin
        addr = dsub[AW-1:0];
        if (dsub >= 32'(size)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_DENSE_CHK;
        end
      end
      S_DENSE_CHK: begin
        if (op == CMD_SET) begin
          dk_we = 1'b1;
          dv_we = 1'b1;
        end else if (op == CMD_INC) begin
          dk_we = 1'b1;
          dv_we = 1'b1;
          vw = dv_q + 32'd1;
        end
        state_next = S_OUT;
      end
      S_RAW_RD: state_next = S_RAW_CHK;
      S_RAW_CHK: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      table_size <= SizeW'(4096);
      sentinel <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        if (cfg_index == REG_SIZE) begin
          table_size <= cfg_data[SizeW-1:0];
        end else begin
          sentinel <= cfg_data;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op <= cmd;
        k <= key;
        nv <= new_value;
        idx <= slot_index;
        use_dense <= 1'b0;
        probes <= '0;
        result_key <= '0;
        result_value <= '0;
        status <= ST_OK;
      end
      S_HASH: begin
        prod <= k * HashMul;
        rem <= k * HashMul;
        dsh <= {size, 31'd0};
        mstep <= '0;
        if (op == CMD_READ) begin
          if (14'(idx) < 14'(size)) begin
            slot <= AW'(idx);
          end else if (ridx < 14'(size)) begin
            slot <= AW'(ridx);
            use_dense <= 1'b1;
          end else begin
            status <= ST_RANGE;
          end
        end else if (k > sentinel) begin
          use_dense <= 1'b1;
        end
      end
      S_MOD: begin
        // restoring reduction, one compare and subtract of a shifted size a cycle
        rem <= rem_step;
        dsh <= dsh >> 1;
        mstep <= mstep + 5'd1;
        if (mstep == 5'd31) begin
          slot <= rem_step[AW-1:0];
        end
      end
      S_PROBE_CHK: begin
        if (hk_q == '0 || hk_q == k) begin
          if (op == CMD_INC) begin
            result_value <= hv_q + 32'd1;
          end else if (op == CMD_GET) begin
            result_value <= hv_q;
          end
        end else begin
          probes <= probes + CW'(1);
          // probe position wraps at 32 bits before it is reduced
          slot <= (prod + 32'(probes) == 32'hFFFF_FFFF ||
                   32'(slot) + 32'd1 >= 32'(size)) ? '0 : slot + AW'(1);
          if (probes == size - CW'(1)) begin
            status <= ST_FULL;
          end
        end
      end
      S_DENSE_RD: begin
        if (dsub >= 32'(size)) begin
          status <= ST_RANGE;
        end else begin
          slot <= dsub[AW-1:0];
        end
      end
      S_DENSE_CHK: begin
        if (op == CMD_INC) begin
          result_value <= dv_q + 32'd1;
        end else if (op == CMD_GET) begin
          result_value <= dv_q;
        end
      end
      S_RAW_CHK: begin
        if (status == ST_OK) begin
          result_key <= cur_k;
          result_value <= cur_v;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, !out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_probe_bound, clk, rst, state == S_PROBE_CHK, probes < size)
endmodule
